@@ src/ssp_pkg.sv @@
// ============================================================================
// ssp_pkg: shared types and constants of the servo slew position controller
// Field widths, command codes, register indexes and the divide-by-100
// reciprocal used by the percent mapping.
// ============================================================================
`default_nettype none

package ssp_pkg;

	localparam int ANGLE_W    = 8;
	localparam int STEP_W     = 4;
	localparam int TIME_W     = 16;
	localparam int COUNT_W    = 16;
	localparam int KIND_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 40;

	localparam int QUEUE_DEPTH_DEF = 4;

	// percent * span fits 16 bits; the quotient by 100 fits 10 bits
	localparam int PROD_W  = 2 * ANGLE_W;
	localparam int QUOT_W  = 10;
	localparam int MAP_W   = QUOT_W + 1;
	// floor(n / 100) == (n * 83887) >> 23 for every n below 91180
	localparam int RECIP_W   = 17;
	localparam int DIV_SHIFT = 23;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 17'd83887;
	localparam int WIDE_W    = PROD_W + RECIP_W;

	localparam logic [ANGLE_W-1:0] TOLERANCE = 8'd2;

	localparam logic [ANGLE_W-1:0] RST_OPEN_POS  = 8'd90;
	localparam logic [ANGLE_W-1:0] RST_CLOSE_POS = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_MIN_POS   = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_MAX_POS   = 8'd180;
	localparam logic [STEP_W-1:0]  RST_STEP_SIZE = 4'd1;
	localparam logic [TIME_W-1:0]  RST_STEP_INTV = 16'd50;
	localparam logic [ANGLE_W-1:0] RST_ANGLE     = 8'd90;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 3'd0,
		KIND_MOVE    = 3'd1,
		KIND_SMOOTH  = 3'd2,
		KIND_OPEN    = 3'd3,
		KIND_CLOSE   = 3'd4,
		KIND_PERCENT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_JUMP   = 2'd2,
		CMD_SMOOTH = 2'd3
	} cmd_op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ENABLED   = 3'd0,
		REG_OPEN_POS  = 3'd1,
		REG_CLOSE_POS = 3'd2,
		REG_MIN_POS   = 3'd3,
		REG_MAX_POS   = 3'd4,
		REG_STEP_SIZE = 3'd5,
		REG_STEP_INTV = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                enabled;
		logic [ANGLE_W-1:0]  open_pos;
		logic [ANGLE_W-1:0]  close_pos;
		logic [ANGLE_W-1:0]  min_pos;
		logic [ANGLE_W-1:0]  max_pos;
		logic [STEP_W-1:0]   step_size;
		logic [TIME_W-1:0]   step_intv;
	} cfg_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [ANGLE_W-1:0]  target;
		logic                in_lim;
	} cmd_t;

	// lowest bit first: accepted, angle, goal, in_motion, at_open, at_closed, moves
	typedef struct packed {
		logic [3:0]          pad;
		logic [COUNT_W-1:0]  moves;
		logic                at_closed;
		logic                at_open;
		logic                in_motion;
		logic [ANGLE_W-1:0]  goal;
		logic [ANGLE_W-1:0]  angle;
		logic                accepted;
	} result_t;

	function automatic logic near_angle(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [ANGLE_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d <= TOLERANCE;
	endfunction

endpackage

`default_nettype wire

@@ src/ssp_front.sv @@
// ============================================================================
// ssp_front: command intake and classification
// Two-stage pipeline: resolve the requested angle (preset, raw or percent
// mapped onto min..max) and check it against the limits.
// ============================================================================
`default_nettype none

module ssp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssp_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ssp_pkg::KIND_W-1:0]  in_kind,
	input  logic [ssp_pkg::ANGLE_W-1:0] in_position,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output ssp_pkg::cmd_t               cmd
);
	import ssp_pkg::*;

	logic                v_s1, v_s2;
	cmd_op_t             op_s1, op_s2;
	logic                pct_s1, pct_s2;
	logic [ANGLE_W-1:0]  p_s1, p_s2;
	logic [PROD_W-1:0]   prod_s1;
	logic [QUOT_W-1:0]   quot_s2;

	logic                ready_s1, ready_s2;
	cmd_op_t             op_c;
	logic                pct_c;
	logic [ANGLE_W-1:0]  p_c;
	logic [ANGLE_W-1:0]  span;
	logic [WIDE_W-1:0]   recip_prod;
	logic [MAP_W-1:0]    mapped;
	logic [MAP_W-1:0]    p_full;

	assign ready_s2 = !v_s2 || cmd_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		op_c  = CMD_NONE;
		pct_c = 1'b0;
		p_c   = in_position;
		case (kind_t'(in_kind))
			KIND_TICK:    op_c = CMD_TICK;
			KIND_MOVE:    op_c = CMD_JUMP;
			KIND_SMOOTH:  op_c = CMD_SMOOTH;
			KIND_OPEN: begin
				op_c = CMD_JUMP;
				p_c  = cfg.open_pos;
			end
			KIND_CLOSE: begin
				op_c = CMD_JUMP;
				p_c  = cfg.close_pos;
			end
			KIND_PERCENT: begin
				op_c  = CMD_JUMP;
				pct_c = 1'b1;
			end
			default:      op_c = CMD_NONE;
		endcase
	end

	// wraps when min is above max; the limit check rejects those anyway
	assign span = cfg.max_pos - cfg.min_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			op_s1   <= op_c;
			pct_s1  <= pct_c;
			p_s1    <= p_c;
			prod_s1 <= PROD_W'(in_position) * PROD_W'(span);
		end
	end

	assign recip_prod = WIDE_W'(prod_s1) * WIDE_W'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			op_s2   <= op_s1;
			pct_s2  <= pct_s1;
			p_s2    <= p_s1;
			quot_s2 <= recip_prod[DIV_SHIFT +: QUOT_W];
		end
	end

	assign mapped = MAP_W'(quot_s2) + MAP_W'(cfg.min_pos);
	assign p_full = pct_s2 ? mapped : MAP_W'(p_s2);

	assign cmd_valid  = v_s2;
	assign cmd.op     = op_s2;
	assign cmd.target = p_full[ANGLE_W-1:0];
	assign cmd.in_lim = (p_full >= MAP_W'(cfg.min_pos)) && (p_full <= MAP_W'(cfg.max_pos));

endmodule

`default_nettype wire

@@ src/ssp_queue.sv @@
// ============================================================================
// ssp_queue: short command queue
// Register-based FIFO between the intake and the execution stage.
// ============================================================================
`default_nettype none

module ssp_queue #(
	parameter int DEPTH = ssp_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ssp_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ssp_pkg::cmd_t pop_data
);
	import ssp_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ src/ssp_back.sv @@
// ============================================================================
// ssp_back: command execution
// Holds the servo state, applies one command per cycle unless the result
// register is stalled, and registers the result for the output channel.
// ============================================================================
`default_nettype none

module ssp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ssp_pkg::cfg_t    cfg,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  ssp_pkg::cmd_t    cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output ssp_pkg::result_t res
);
	import ssp_pkg::*;

	logic [ANGLE_W-1:0]  cur_q, tgt_q;
	logic                moving_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	result_t             res_q;

	logic                take;
	logic [TIME_W-1:0]   el_inc;
	logic                up;
	logic [ANGLE_W-1:0]  delta, step, cur_step;
	logic [ANGLE_W-1:0]  cur_n, tgt_n;
	logic                mov_n, ok;
	logic [TIME_W-1:0]   el_n;
	logic [COUNT_W-1:0]  cnt_n;
	result_t             res_n;

	assign cmd_ready = !out_valid_q || res_ready;
	assign take      = cmd_valid && cmd_ready;
	assign res_valid = out_valid_q;
	assign res       = res_q;

	// saturate the timer
	assign el_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign up       = tgt_q > cur_q;
	assign delta    = up ? tgt_q - cur_q : cur_q - tgt_q;
	assign step     = (ANGLE_W'(cfg.step_size) < delta) ? ANGLE_W'(cfg.step_size) : delta;
	assign cur_step = up ? cur_q + step : cur_q - step;

	always_comb begin
		cur_n = cur_q;
		tgt_n = tgt_q;
		mov_n = moving_q;
		el_n  = elapsed_q;
		cnt_n = count_q;
		ok    = 1'b0;
		if (cfg.enabled) begin
			case (cmd.op)
				CMD_TICK: begin
					ok   = 1'b1;
					el_n = el_inc;
					if (moving_q && (el_inc >= cfg.step_intv)) begin
						if (cur_q == tgt_q) begin
							mov_n = 1'b0;
						end else begin
							cur_n = cur_step;
							el_n  = '0;
							mov_n = (cur_step != tgt_q);
						end
					end
				end
				CMD_JUMP: begin
					if (cmd.in_lim) begin
						ok = 1'b1;
						if (cmd.target != cur_q) begin
							cur_n = cmd.target;
							tgt_n = cmd.target;
							el_n  = '0;
							cnt_n = count_q + 1'b1;
						end
					end
				end
				CMD_SMOOTH: begin
					if (cmd.in_lim) begin
						ok    = 1'b1;
						tgt_n = cmd.target;
						mov_n = 1'b1;
						cnt_n = count_q + 1'b1;
					end
				end
				default: ok = 1'b0;
			endcase
		end
	end

	always_comb begin
		res_n           = '0;
		res_n.accepted  = ok;
		res_n.angle     = cur_n;
		res_n.goal      = tgt_n;
		res_n.in_motion = mov_n;
		res_n.at_open   = near_angle(cur_n, cfg.open_pos);
		res_n.at_closed = near_angle(cur_n, cfg.close_pos);
		res_n.moves     = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= RST_ANGLE;
			tgt_q       <= RST_ANGLE;
			moving_q    <= 1'b0;
			elapsed_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cur_q     <= cur_n;
				tgt_q     <= tgt_n;
				moving_q  <= mov_n;
				elapsed_q <= el_n;
				count_q   <= cnt_n;
			end
			if (cmd_ready) out_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res_n;
	end

endmodule

`default_nettype wire

@@ src/servo_slew_position_controller.sv @@
// ============================================================================
// servo_slew_position_controller: servo angle control with slew limiting
// Takes tick and move commands, keeps the servo angle, target and move count.
// ============================================================================
// Usage:
//   Commands enter on the s_axis stream: tuser carries the command kind,
//   tdata the requested angle (or percent). Each accepted command gives
//   exactly one result transaction on m_axis reporting the state after it.
//   Registers are written on the cfg channel, which is always ready; write
//   them only while no command is in flight.
// Pipeline and throughput:
//   A command passes two intake stages (the second holds the multiply by
//   the reciprocal of 100 for percent moves), the command queue, then the
//   execution stage, which registers the result. One command per cycle is
//   sustained while m_axis_tready is high; the execution stage applies one
//   command per cycle to the servo state.
// Reset:
//   arst_n clears the pipeline and queue, loads the register defaults and
//   parks the servo at 90 degrees with a zero timer and move count.
// Stalls:
//   While m_axis_tready is low the result register holds; the queue keeps
//   absorbing commands until it fills, then s_axis_tready drops.
// ============================================================================
`default_nettype none

module servo_slew_position_controller #(
	parameter int QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ssp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] position
	input  logic [ssp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [2:0] kind
	// result channel
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] accepted, [8:1] angle, [16:9] goal, [17] in_motion, [18] at_open,
	// [19] at_closed, [35:20] moves, [39:36] zero
	output logic [ssp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssp_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ssp_pkg::*;

	cfg_t    cfg_q;
	logic    cmd_valid_f, cmd_ready_f;
	cmd_t    cmd_f;
	logic    cmd_valid_b, cmd_ready_b;
	cmd_t    cmd_b;
	result_t res;

	// Register file: the channel never stalls; unknown indexes drop the write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled   <= 1'b0;
			cfg_q.open_pos  <= RST_OPEN_POS;
			cfg_q.close_pos <= RST_CLOSE_POS;
			cfg_q.min_pos   <= RST_MIN_POS;
			cfg_q.max_pos   <= RST_MAX_POS;
			cfg_q.step_size <= RST_STEP_SIZE;
			cfg_q.step_intv <= RST_STEP_INTV;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_addr))
				REG_ENABLED:   cfg_q.enabled   <= cfg_data[0];
				REG_OPEN_POS:  cfg_q.open_pos  <= cfg_data[ANGLE_W-1:0];
				REG_CLOSE_POS: cfg_q.close_pos <= cfg_data[ANGLE_W-1:0];
				REG_MIN_POS:   cfg_q.min_pos   <= cfg_data[ANGLE_W-1:0];
				REG_MAX_POS:   cfg_q.max_pos   <= cfg_data[ANGLE_W-1:0];
				REG_STEP_SIZE: cfg_q.step_size <= cfg_data[STEP_W-1:0];
				REG_STEP_INTV: cfg_q.step_intv <= cfg_data[TIME_W-1:0];
				default:       cfg_q.enabled   <= cfg_q.enabled;
			endcase
		end
	end

	// Intake: classify, resolve presets and percent mapping, limit check.
	ssp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tuser[KIND_W-1:0]),
		.in_position (s_axis_tdata[ANGLE_W-1:0]),
		.cmd_valid   (cmd_valid_f),
		.cmd_ready   (cmd_ready_f),
		.cmd         (cmd_f)
	);

	// Decouple intake from execution so each side can stall on its own.
	ssp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid_f),
		.push_ready (cmd_ready_f),
		.push_data  (cmd_f),
		.pop_valid  (cmd_valid_b),
		.pop_ready  (cmd_ready_b),
		.pop_data   (cmd_b)
	);

	// Execution: tick stepping, jumps, smooth targets, result register.
	ssp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid_b),
		.cmd_ready (cmd_ready_b),
		.cmd       (cmd_b),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = res;

endmodule

`default_nettype wire

@@ src/ssp_checker.sv @@
// ============================================================================
// ssp_checker: port-level checks of the servo slew position controller
// Watches the streams and flags results without a command, held results
// that change, move counts that jump and rejections that alter state.
// ============================================================================
`default_nettype none

module ssp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [ssp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ssp_pkg::*;

	result_t             r;
	logic                in_acc, out_acc;
	logic [7:0]          pending_q;
	logic [ANGLE_W-1:0]  last_angle_q, last_goal_q;
	logic [COUNT_W-1:0]  last_moves_q;

	assign r       = m_axis_tdata;
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// track commands in flight and the last delivered state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_angle_q <= RST_ANGLE;
			last_goal_q  <= RST_ANGLE;
			last_moves_q <= '0;
		end else begin
			pending_q <= pending_q + 8'(in_acc) - 8'(out_acc);
			if (out_acc) begin
				last_angle_q <= r.angle;
				last_goal_q  <= r.goal;
				last_moves_q <= r.moves;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("result without a pending command");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (r.moves == last_moves_q) || (r.moves == last_moves_q + 16'd1))
		else $error("move count skipped");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !r.accepted |->
			(r.angle == last_angle_q) && (r.goal == last_goal_q) &&
			(r.moves == last_moves_q))
		else $error("rejected command changed servo state");

endmodule

bind servo_slew_position_controller ssp_checker u_ssp_checker (.*);

`default_nettype wire
